// ----- hdl/sgm_pkg.sv -----
// Package for the SiLU gate multiply block: widths, item types and the sigmoid table
// builder. It has no dependencies. Every other file in hdl imports it.
`timescale 1ns / 1ps
`default_nettype none

package sgm_pkg;

   localparam int unsigned SIGMOID_TABLE_ENTRIES = 256;
   localparam int unsigned SAMPLE_WIDTH          = 16;

   localparam int unsigned FRAC_BITS  = SAMPLE_WIDTH - 4;
   localparam int unsigned SIG_POINTS = SIGMOID_TABLE_ENTRIES + 1;
   localparam int unsigned PT_IDX_W   = $clog2(SIG_POINTS);
   localparam int unsigned P_W        = SAMPLE_WIDTH + PT_IDX_W;
   localparam int unsigned TAB_W      = 17;
   localparam int unsigned DIFF_W     = TAB_W + 1;
   localparam int unsigned CORR_W     = DIFF_W + SAMPLE_WIDTH + 1;
   localparam int unsigned SILU_W     = SAMPLE_WIDTH + TAB_W + 1;
   localparam int unsigned S24_W      = 29;
   localparam int unsigned PROD_W     = S24_W + SAMPLE_WIDTH;
   localparam int unsigned PRODUCT_W  = 32;

   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [SAMPLE_WIDTH-1:0]        frac_type;
   typedef logic [TAB_W-1:0]               tab_type;
   typedef logic signed [DIFF_W-1:0]       diff_type;
   typedef logic signed [PRODUCT_W-1:0]    product_type;

   typedef struct packed {
      logic valid;
      logic last;
   } item_ctl_type;

   // Restoring division, used only while building the table.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Sigmoid at point i of the table, unsigned Q1.16 with 1.0 = 65536.
   function automatic tab_type sigmoid_point(input int unsigned i);
      logic [63:0] t;
      logic [63:0] twice;
      logic [63:0] distance;
      logic [63:0] y;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] s;
      t        = 64'(SIGMOID_TABLE_ENTRIES);
      twice    = 64'(i) << 1;
      distance = (twice >= t) ? (twice - t) : (t - twice);
      y        = udiv64(distance << 30, t);
      sum   = ONE_Q30;
      term  = ONE_Q30;
      for (int n = 1; n <= 16; n++) begin
         term = udiv64((term * y) >> 30, 64'(n));
         if (n[0]) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      e = sum;
      for (int k = 0; k < 3; k++) begin
         e = (e * e) >> 30;
      end
      den = ONE_Q30 + e;
      s   = udiv64((64'd1 << 46) + (den >> 1), den);
      if (twice < t) begin
         s = 64'd65536 - s;
      end
      return s[TAB_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- hdl/sgm_if.sv -----
// Valid/ready channel interfaces for request and response items.
// Depends on sgm_pkg for the sample and product types.
`timescale 1ns / 1ps
`default_nettype none

interface sgm_req_if import sgm_pkg::*;;
   logic       valid;
   logic       ready;
   sample_type gate;
   sample_type up;
   logic       last_in;

   modport source (output valid, output gate, output up, output last_in, input ready);
   modport sink   (input valid, input gate, input up, input last_in, output ready);
endinterface

interface sgm_rsp_if import sgm_pkg::*;;
   logic        valid;
   logic        ready;
   product_type product;
   logic        last_out;

   modport source (output valid, output product, output last_out, input ready);
   modport sink   (input valid, input product, input last_out, output ready);
endinterface

`default_nettype wire

// ----- hdl/silu_gate_multiply.sv -----
// SiLU gate multiply: product = gate * sigmoid(gate) * up, Q4.12 in and Q8.24 out, with the
// last flag carried alongside. One item is taken every cycle unless the result side stalls,
// and each result passes through the eight register stages of the datapath (index, table
// read, slope multiply, interpolation add, gate multiply, rescale, up multiply, output
// rounding), each holding one multiplier or one add. Every stage has its own valid bit
// and moves whenever the stage after it is empty or moving, so the result register is the
// only place a stall starts and bubbles are squeezed out. The sigmoid is a 257-point constant
// table over [-8, +8] with linear interpolation; there is no state and no start-up sweep.
// Depends on sgm_pkg, sgm_if, sgm_lookup, sgm_interp and sgm_product.
`timescale 1ns / 1ps
`default_nettype none

module silu_gate_multiply import sgm_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   sgm_req_if.sink     req_if,
   sgm_rsp_if.source   rsp_if
);

   item_ctl_type in_ctl;

   item_ctl_type lk_ctl;
   tab_type      lk_base;
   diff_type     lk_diff;
   frac_type     lk_frac;
   sample_type   lk_gate;
   sample_type   lk_up;
   logic         lk_ready;

   item_ctl_type ip_ctl;
   tab_type      ip_sig;
   sample_type   ip_gate;
   sample_type   ip_up;
   logic         ip_ready;

   logic         pr_ready;
   item_ctl_type pr_ctl;
   product_type  pr_product;

   assign in_ctl = '{valid: req_if.valid, last: req_if.last_in};

   sgm_lookup u_lookup (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (in_ctl),
      .in_gate   (req_if.gate),
      .in_up     (req_if.up),
      .in_ready  (lk_ready),
      .out_ctl   (lk_ctl),
      .out_base  (lk_base),
      .out_diff  (lk_diff),
      .out_frac  (lk_frac),
      .out_gate  (lk_gate),
      .out_up    (lk_up),
      .out_ready (ip_ready)
   );

   sgm_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (lk_ctl),
      .in_base   (lk_base),
      .in_diff   (lk_diff),
      .in_frac   (lk_frac),
      .in_gate   (lk_gate),
      .in_up     (lk_up),
      .in_ready  (ip_ready),
      .out_ctl   (ip_ctl),
      .out_sig   (ip_sig),
      .out_gate  (ip_gate),
      .out_up    (ip_up),
      .out_ready (pr_ready)
   );

   sgm_product u_product (
      .clock       (clock),
      .reset       (reset),
      .in_ctl      (ip_ctl),
      .in_sig      (ip_sig),
      .in_gate     (ip_gate),
      .in_up       (ip_up),
      .in_ready    (pr_ready),
      .out_ctl     (pr_ctl),
      .out_product (pr_product),
      .out_ready   (rsp_if.ready)
   );

   assign req_if.ready    = lk_ready;
   assign rsp_if.valid    = pr_ctl.valid;
   assign rsp_if.product  = pr_product;
   assign rsp_if.last_out = pr_ctl.last;

   // A free output register lets the whole pipeline advance.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.ready |-> req_if.ready)
      else $error("input stalled while the result side is ready");

   // With the result side ready throughout, an item emerges after eight stages.
   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && rsp_if.ready) ##1 rsp_if.ready ##1 rsp_if.ready
      ##1 rsp_if.ready ##1 rsp_if.ready ##1 rsp_if.ready ##1 rsp_if.ready
      ##1 rsp_if.ready |=> rsp_if.valid)
      else $error("accepted item did not reach the output in eight cycles");

   // Drop all items in flight on reset.
   assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("result valid after reset");

endmodule

`default_nettype wire

// ----- hdl/sgm_lookup.sv -----
// Stages 1 and 2: sigmoid table index and fraction, then table read and slope.
// Depends on sgm_pkg for widths, item control type and the table builder.
`timescale 1ns / 1ps
`default_nettype none

module sgm_lookup import sgm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire item_ctl_type in_ctl,
   input  wire sample_type   in_gate,
   input  wire sample_type   in_up,
   output logic              in_ready,
   output item_ctl_type      out_ctl,
   output tab_type           out_base,
   output diff_type          out_diff,
   output frac_type          out_frac,
   output sample_type        out_gate,
   output sample_type        out_up,
   input  wire logic         out_ready
);

   tab_type sig_lut [SIG_POINTS];

   for (genvar i = 0; i < SIG_POINTS; i++) begin : g_lut
      localparam tab_type POINT = sigmoid_point(i);
      assign sig_lut[i] = POINT;
   end

   logic s1_en;
   logic s2_en;

   item_ctl_type           s1_ctl_ff;
   logic [PT_IDX_W-1:0]    s1_idx_ff;
   logic [PT_IDX_W-1:0]    s1_idx_in;
   frac_type               s1_frac_ff;
   frac_type               s1_frac_in;
   sample_type             s1_gate_ff;
   sample_type             s1_up_ff;
   logic [SAMPLE_WIDTH-1:0] offset;
   logic [P_W-1:0]         scaled;

   item_ctl_type s2_ctl_ff;
   tab_type      s2_base_ff;
   tab_type      s2_base_in;
   diff_type     s2_diff_ff;
   diff_type     s2_diff_in;
   frac_type     s2_frac_ff;
   sample_type   s2_gate_ff;
   sample_type   s2_up_ff;
   tab_type      next_point;

   assign s2_en    = ~s2_ctl_ff.valid | out_ready;
   assign s1_en    = ~s1_ctl_ff.valid | s2_en;
   assign in_ready = s1_en;

   // Offset binary of the gate is gate + 8.0 in Q4.F.
   assign offset     = {~in_gate[SAMPLE_WIDTH-1], in_gate[SAMPLE_WIDTH-2:0]};
   assign scaled     = P_W'(offset) * P_W'(SIGMOID_TABLE_ENTRIES);
   assign s1_idx_in  = scaled[P_W-1:SAMPLE_WIDTH];
   assign s1_frac_in = scaled[SAMPLE_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (s1_en) begin
         s1_ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_idx_ff  <= s1_idx_in;
         s1_frac_ff <= s1_frac_in;
         s1_gate_ff <= in_gate;
         s1_up_ff   <= in_up;
      end
   end

   assign s2_base_in = sig_lut[s1_idx_ff];
   assign next_point = sig_lut[s1_idx_ff + PT_IDX_W'(1)];
   assign s2_diff_in = $signed({1'b0, next_point}) - $signed({1'b0, s2_base_in});

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else if (s2_en) begin
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_base_ff <= s2_base_in;
         s2_diff_ff <= s2_diff_in;
         s2_frac_ff <= s1_frac_ff;
         s2_gate_ff <= s1_gate_ff;
         s2_up_ff   <= s1_up_ff;
      end
   end

   assign out_ctl  = s2_ctl_ff;
   assign out_base = s2_base_ff;
   assign out_diff = s2_diff_ff;
   assign out_frac = s2_frac_ff;
   assign out_gate = s2_gate_ff;
   assign out_up   = s2_up_ff;

endmodule

`default_nettype wire

// ----- hdl/sgm_interp.sv -----
// Stages 3 and 4: slope times fraction, then truncated correction added to the base point.
// Depends on sgm_pkg for widths and the item control type.
`timescale 1ns / 1ps
`default_nettype none

module sgm_interp import sgm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire item_ctl_type in_ctl,
   input  wire tab_type      in_base,
   input  wire diff_type     in_diff,
   input  wire frac_type     in_frac,
   input  wire sample_type   in_gate,
   input  wire sample_type   in_up,
   output logic              in_ready,
   output item_ctl_type      out_ctl,
   output tab_type           out_sig,
   output sample_type        out_gate,
   output sample_type        out_up,
   input  wire logic         out_ready
);

   localparam logic signed [CORR_W-1:0] FRAC_MASK =
      CORR_W'((64'd1 << SAMPLE_WIDTH) - 64'd1);

   logic s3_en;
   logic s4_en;

   item_ctl_type             s3_ctl_ff;
   logic signed [CORR_W-1:0] s3_mult_ff;
   logic signed [CORR_W-1:0] s3_mult_in;
   tab_type                  s3_base_ff;
   sample_type               s3_gate_ff;
   sample_type               s3_up_ff;

   item_ctl_type             s4_ctl_ff;
   tab_type                  s4_sig_ff;
   tab_type                  s4_sig_in;
   sample_type               s4_gate_ff;
   sample_type               s4_up_ff;
   logic signed [CORR_W-1:0] corr_bias;
   logic signed [CORR_W-1:0] corr_biased;
   logic signed [CORR_W-1:0] corr;
   logic [TAB_W+1:0]         sig_sum;

   assign s4_en    = ~s4_ctl_ff.valid | out_ready;
   assign s3_en    = ~s3_ctl_ff.valid | s4_en;
   assign in_ready = s3_en;

   assign s3_mult_in = in_diff * $signed({1'b0, in_frac});

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else if (s3_en) begin
         s3_ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_mult_ff <= s3_mult_in;
         s3_base_ff <= in_base;
         s3_gate_ff <= in_gate;
         s3_up_ff   <= in_up;
      end
   end

   // Bias negative values so the shift truncates toward zero.
   assign corr_bias   = s3_mult_ff[CORR_W-1] ? FRAC_MASK : '0;
   assign corr_biased = s3_mult_ff + corr_bias;
   assign corr        = corr_biased >>> SAMPLE_WIDTH;
   assign sig_sum     = {2'b00, s3_base_ff} + corr[TAB_W+1:0];
   assign s4_sig_in   = sig_sum[TAB_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctl_ff <= '0;
      end else if (s4_en) begin
         s4_ctl_ff <= s3_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_en) begin
         s4_sig_ff  <= s4_sig_in;
         s4_gate_ff <= s3_gate_ff;
         s4_up_ff   <= s3_up_ff;
      end
   end

   assign out_ctl  = s4_ctl_ff;
   assign out_sig  = s4_sig_ff;
   assign out_gate = s4_gate_ff;
   assign out_up   = s4_up_ff;

endmodule

`default_nettype wire

// ----- hdl/sgm_product.sv -----
// Stages 5 to 8: gate times sigmoid, rescale to Q24, times up, round to the Q8.24 result.
// Depends on sgm_pkg for widths and the item control type.
`timescale 1ns / 1ps
`default_nettype none

module sgm_product import sgm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire item_ctl_type in_ctl,
   input  wire tab_type      in_sig,
   input  wire sample_type   in_gate,
   input  wire sample_type   in_up,
   output logic              in_ready,
   output item_ctl_type      out_ctl,
   output product_type       out_product,
   input  wire logic         out_ready
);

   localparam int unsigned WIDE_W   = SILU_W + 8;
   localparam int unsigned ROUND_SH = (FRAC_BITS >= 8) ? (FRAC_BITS - 8) : 0;
   localparam int unsigned LEFT_SH  = (FRAC_BITS < 8) ? (8 - FRAC_BITS) : 0;
   localparam logic signed [PROD_W:0] PROD_HALF = (PROD_W + 1)'(64'd1 << (FRAC_BITS - 1));

   logic s5_en;
   logic s6_en;
   logic s7_en;
   logic s8_en;

   item_ctl_type             s5_ctl_ff;
   logic signed [SILU_W-1:0] s5_silu_ff;
   logic signed [SILU_W-1:0] s5_silu_in;
   sample_type               s5_up_ff;

   item_ctl_type             s6_ctl_ff;
   logic signed [S24_W-1:0]  s6_silu24_ff;
   logic signed [S24_W-1:0]  s6_silu24_in;
   sample_type               s6_up_ff;
   logic signed [WIDE_W-1:0] silu_wide;
   logic signed [WIDE_W-1:0] silu_scaled;

   item_ctl_type             s7_ctl_ff;
   logic signed [PROD_W-1:0] s7_prod_ff;
   logic signed [PROD_W-1:0] s7_prod_in;

   item_ctl_type             s8_ctl_ff;
   product_type              s8_product_ff;
   product_type              s8_product_in;
   logic signed [PROD_W:0]   prod_wide;
   logic signed [PROD_W:0]   prod_rounded;

   assign s8_en    = ~s8_ctl_ff.valid | out_ready;
   assign s7_en    = ~s7_ctl_ff.valid | s8_en;
   assign s6_en    = ~s6_ctl_ff.valid | s7_en;
   assign s5_en    = ~s5_ctl_ff.valid | s6_en;
   assign in_ready = s5_en;

   assign s5_silu_in = in_gate * $signed({1'b0, in_sig});

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_ctl_ff <= '0;
      end else if (s5_en) begin
         s5_ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_en) begin
         s5_silu_ff <= s5_silu_in;
         s5_up_ff   <= in_up;
      end
   end

   assign silu_wide = {{(WIDE_W - SILU_W){s5_silu_ff[SILU_W-1]}}, s5_silu_ff};

   if (ROUND_SH > 0) begin : g_round
      localparam logic signed [WIDE_W-1:0] SILU_HALF = WIDE_W'(64'd1 << (ROUND_SH - 1));
      assign silu_scaled = (silu_wide + SILU_HALF) >>> ROUND_SH;
   end else begin : g_left
      assign silu_scaled = silu_wide <<< LEFT_SH;
   end

   assign s6_silu24_in = silu_scaled[S24_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_ctl_ff <= '0;
      end else if (s6_en) begin
         s6_ctl_ff <= s5_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s6_en) begin
         s6_silu24_ff <= s6_silu24_in;
         s6_up_ff     <= s5_up_ff;
      end
   end

   assign s7_prod_in = s6_silu24_ff * s6_up_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_ctl_ff <= '0;
      end else if (s7_en) begin
         s7_ctl_ff <= s6_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s7_en) begin
         s7_prod_ff <= s7_prod_in;
      end
   end

   // Round half up to 24 fraction bits.
   assign prod_wide     = {s7_prod_ff[PROD_W-1], s7_prod_ff};
   assign prod_rounded  = (prod_wide + PROD_HALF) >>> FRAC_BITS;
   assign s8_product_in = prod_rounded[PRODUCT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_ctl_ff <= '0;
      end else if (s8_en) begin
         s8_ctl_ff <= s7_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s8_en) begin
         s8_product_ff <= s8_product_in;
      end
   end

   assign out_ctl     = s8_ctl_ff;
   assign out_product = s8_product_ff;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Testbench for silu_gate_multiply: random and directed gate/up items over valid/ready channels,
// with a scoreboard class that predicts each Q8.24 product from its own sigmoid table.
// Depends on sgm_pkg, sgm_if and the silu_gate_multiply RTL.
`timescale 1ns / 1ps

module tb_top import sgm_pkg::*;;

   localparam int unsigned RANDOM_ITEMS = 1300;
   localparam int unsigned DRAIN_CYCLES = 16;

   typedef struct {
      product_type product;
      logic        last;
   } expected_result_type;

   class product_board;
      tab_type             sig_points [0:SIGMOID_TABLE_ENTRIES];
      expected_result_type pending_products [$];
      int unsigned         errors;
      int unsigned         checked;

      function new();
         errors  = 0;
         checked = 0;
         fill_sigmoid();
      endfunction

      function automatic longint unsigned exp_neg_q30(longint unsigned y);
         longint unsigned term;
         longint          acc;
         term = 64'd1 << 30;
         acc  = 64'd1 << 30;
         for (int n = 1; n <= 16; n++) begin
            term = ((term * y) >> 30) / longint'(n);
            if (n % 2 == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         return longint'(acc);
      endfunction

      function void fill_sigmoid();
         longint unsigned span_t;
         longint unsigned twice;
         longint unsigned distance;
         longint unsigned e;
         longint unsigned den;
         longint unsigned s;
         span_t = SIGMOID_TABLE_ENTRIES;
         for (int i = 0; i <= SIGMOID_TABLE_ENTRIES; i++) begin
            twice    = 2 * i;
            distance = (twice >= span_t) ? twice - span_t : span_t - twice;
            e        = exp_neg_q30((distance << 30) / span_t);
            for (int k = 0; k < 3; k++) begin
               e = (e * e) >> 30;
            end
            den = (64'd1 << 30) + e;
            s   = ((64'd1 << 46) + den / 2) / den;
            if (twice < span_t) begin
               s = 64'd65536 - s;
            end
            sig_points[i] = s[TAB_W-1:0];
         end
      endfunction

      function product_type swiglu_product(sample_type g, sample_type u);
         logic [SAMPLE_WIDTH-1:0] offset;
         longint unsigned         p;
         longint unsigned         span;
         longint unsigned         idx;
         longint                  frac;
         longint                  diff;
         longint                  corr;
         longint                  sig;
         longint                  silu;
         longint                  silu24;
         longint                  prod;
         offset = {~g[SAMPLE_WIDTH-1], g[SAMPLE_WIDTH-2:0]};
         span   = 64'd1 << (FRAC_BITS + 4);
         p      = longint'(offset) * SIGMOID_TABLE_ENTRIES;
         idx    = p >> (FRAC_BITS + 4);
         frac   = longint'(p & (span - 1));
         if (idx >= SIGMOID_TABLE_ENTRIES) begin
            idx = SIGMOID_TABLE_ENTRIES - 1;
         end
         diff = longint'(sig_points[idx+1]) - longint'(sig_points[idx]);
         corr = (diff * frac) / longint'(span);
         sig  = longint'(sig_points[idx]) + corr;
         silu = longint'(g) * sig;
         if (FRAC_BITS > 8) begin
            silu24 = (silu + (64'sd1 << (FRAC_BITS - 9))) >>> (FRAC_BITS - 8);
         end else begin
            silu24 = silu <<< (8 - FRAC_BITS);
         end
         prod = (silu24 * longint'(u) + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
         return prod[PRODUCT_W-1:0];
      endfunction

      function void note_item(sample_type g, sample_type u, logic last);
         expected_result_type exp_r;
         exp_r.product = swiglu_product(g, u);
         exp_r.last    = last;
         pending_products.push_back(exp_r);
      endfunction

      function void check_result(product_type product, logic last);
         expected_result_type exp_r;
         if (pending_products.size() == 0) begin
            $display("%0t: result with nothing expected, product %0d last %0b",
                     $time, product, last);
            errors++;
            return;
         end
         exp_r = pending_products.pop_front();
         checked++;
         if (product !== exp_r.product) begin
            $display("%0t: product mismatch, expected %0d actual %0d",
                     $time, exp_r.product, product);
            errors++;
         end
         if (last !== exp_r.last) begin
            $display("%0t: last_out mismatch, expected %0b actual %0b",
                     $time, exp_r.last, last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   sgm_req_if req_ch ();
   sgm_rsp_if rsp_ch ();

   silu_gate_multiply u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   product_board tracker = new();
   int unsigned  req_idle_pct = 33;
   int unsigned  items_sent   = 0;
   int unsigned  last_flags   = 0;
   int unsigned  directed     = 0;
   bit           stall_done   = 1'b0;

   always #5 clock = ~clock;

   task automatic send_item(input sample_type g, input sample_type u, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.gate    <= g;
      req_ch.up      <= u;
      req_ch.last_in <= last;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      tracker.note_item(g, u, last);
      items_sent++;
      if (last) begin
         last_flags++;
      end
   endtask

   task automatic send_directed();
      sample_type gates [12];
      sample_type ups   [4];
      gates = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, -16'sd16384, 16'sd16384,
                16'sd256, -16'sd256, 16'sd4096, -16'sd4096, 16'sd128};
      ups   = '{16'sd32767, -16'sd32768, 16'sd0, 16'sd4096};
      foreach (gates[i]) begin
         send_item(gates[i], ups[i % 4], logic'(i % 5 == 4));
      end
      foreach (ups[j]) begin
         send_item(-16'sd32768, ups[j], 1'b0);
         send_item(16'sd32767, ups[j], logic'(j == 3));
      end
      directed = items_sent;
   endtask

   task automatic send_random();
      sample_type g;
      sample_type u;
      int unsigned kind;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         req_idle_pct = (n >= 500 && n < 700) ? 0 : 33;
         kind = $urandom_range(9);
         g    = sample_type'($urandom_range(16'hFFFF));
         u    = sample_type'($urandom_range(16'hFFFF));
         case (kind)
            6, 7: begin
               g = sample_type'($urandom_range(16383)) - 16'sd8192;
            end
            8: begin
               g = sample_type'({$urandom_range(8'hFF), 8'h00});
            end
            9: begin
               u = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            end
            default: begin
            end
         endcase
         send_item(g, u, logic'($urandom_range(15) == 0));
      end
   endtask

   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            tracker.check_result(rsp_ch.product, rsp_ch.last_out);
         end
         if (!stall_done && tracker.checked >= 300) begin
            stall_done = 1'b1;
            hold_left  = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (req_idle_pct == 0) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= 33);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int unsigned guard;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.gate    <= '0;
      req_ch.up      <= '0;
      req_ch.last_in <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_directed();
      send_random();
      req_ch.valid <= 1'b0;
      guard = 0;
      while (tracker.pending_products.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.pending_products.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, tracker.pending_products.size());
         tracker.errors++;
      end
      $display("Sent %0d items (%0d directed, %0d with the end flag), checked %0d results.",
               items_sent, directed, last_flags, tracker.checked);
      $display("Run included idle-free stretches and a long response stall; %0d errors.",
               tracker.errors);
      if (tracker.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- silu_gate_multiply.f -----
hdl/sgm_pkg.sv
hdl/sgm_if.sv
hdl/sgm_lookup.sv
hdl/sgm_interp.sv
hdl/sgm_product.sv
hdl/silu_gate_multiply.sv
bench/tb_top.sv
